### rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/itb_pkg.sv
package itb_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int CMD_W = 3;
	localparam int IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} itb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} itb_sts_t;

endpackage

### rtl/interval_timer_bank_unit.sv
// flow: a transaction is accepted in idle, which does the registered read of the slot stamp
// memory; an execute step then updates state and registers the result. The execute step
// waits while a result is unclaimed, and no new transaction is accepted until it is done
// reset: asynchronous, clears the millisecond counter, the slot count, the pause flag
// and the handshake state; slot stamps are not cleared and are written by create
`include "assert_macros.svh"

module interval_timer_bank_unit #(
	parameter int TIMER_SLOTS = itb_pkg::TIMER_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// timer_index [3:0], period_ms [35:4], restamp_when_paused [36], zero [39:37]
	input  logic [itb_pkg::IN_DATA_W-1:0]  s_tdata,
	// cmd [2:0]
	input  logic [itb_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_value [31:0]
	output logic [itb_pkg::OUT_DATA_W-1:0] m_tdata,
	// error [0]
	output logic                           m_tuser,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata
);
	import itb_pkg::*;

	itb_cmd_t ctl;
	itb_sts_t sts;

	itb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	itb_dp #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts)
	);

	// the input side is not ready in the cycle after an accepted transaction
	`ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a new result appears only from an execute step
	`ASSERT_SAME(a_result_from_exec, $rose(m_tvalid), $past(ctl.exec))
	// execute never overwrites an unclaimed result
	`ASSERT_SAME(a_exec_out_free, ctl.exec, !m_tvalid || m_tready)
	// after execute the input side opens again
	`ASSERT_NEXT(a_ready_after_exec, ctl.exec, s_tready)

endmodule

### rtl/itb_ctrl.sv
module itb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  itb_pkg::itb_sts_t sts,
	output itb_pkg::itb_cmd_t ctl
);
	import itb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold the fetched stamp until the result register frees up
				if (sts.out_free) begin
					ctl.exec = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

### rtl/itb_dp.sv
module itb_dp #(
	parameter int TIMER_SLOTS = itb_pkg::TIMER_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [itb_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [itb_pkg::CMD_W-1:0]     s_tuser,
	output logic [itb_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  itb_pkg::itb_cmd_t             ctl,
	output itb_pkg::itb_sts_t             sts
);
	import itb_pkg::*;

	localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	logic [TIME_W-1:0] mem [TIMER_SLOTS];

	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] period_q;
	logic              restamp_q;
	logic [TIME_W-1:0] stamp_q;
	logic [TIME_W-1:0] now_q;
	logic [CW-1:0]     cnt_q;
	logic              paused_q;
	logic [TIME_W-1:0] res_value_q;
	logic              res_err_q;
	logic              out_valid_q;

	logic [IDX_W-1:0]  in_idx;
	logic [AW-1:0]     rd_addr;
	logic              slot_ok;
	logic              bank_full;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] period_eff;
	logic              expired;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [TIME_W-1:0] now_nx;
	logic [CW-1:0]     cnt_nx;
	logic [TIME_W-1:0] value_nx;
	logic              err_nx;

	assign in_idx = s_tdata[IDX_W-1:0];
	assign rd_addr = AW'(in_idx);

	assign slot_ok = CMPW'(idx_q) < CMPW'(cnt_q);
	assign bank_full = (cnt_q == CW'(TIMER_SLOTS));
	assign elapsed = now_q - stamp_q;
	assign period_eff = (period_q == '0) ? TIME_W'(1) : period_q;
	assign expired = elapsed > period_eff;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(idx_q);
		now_nx = now_q;
		cnt_nx = cnt_q;
		value_nx = '0;
		err_nx = 1'b0;
		case (cmd_q)
			CMD_TICK: begin
				now_nx = now_q + TIME_W'(1);
				value_nx = now_nx;
			end
			CMD_CREATE: begin
				if (bank_full) begin
					err_nx = 1'b1;
				end else begin
					wr_en = 1'b1;
					wr_addr = AW'(cnt_q);
					value_nx = TIME_W'(cnt_q);
					cnt_nx = cnt_q + CW'(1);
				end
			end
			CMD_CHECK: begin
				if (!slot_ok) begin
					err_nx = 1'b1;
				end else if (paused_q) begin
					wr_en = restamp_q;
				end else if (expired) begin
					wr_en = 1'b1;
					value_nx = elapsed;
				end
			end
			CMD_UPDATE: begin
				if (!slot_ok) begin
					err_nx = 1'b1;
				end else begin
					wr_en = !paused_q;
				end
			end
			CMD_READ: begin
				if (!slot_ok) begin
					err_nx = 1'b1;
				end else begin
					value_nx = elapsed;
				end
			end
			default: begin
			end
		endcase
	end

	// stamp store: registered read on accept, write at execute
	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= now_q;
		end
		if (ctl.load) begin
			stamp_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= s_tuser;
			idx_q <= in_idx;
			period_q <= s_tdata[IDX_W +: TIME_W];
			restamp_q <= s_tdata[IDX_W + TIME_W];
		end
		if (ctl.exec) begin
			res_value_q <= value_nx;
			res_err_q <= err_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			cnt_q <= '0;
			paused_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				paused_q <= cfg_wdata;
			end
			if (ctl.exec) begin
				now_q <= now_nx;
				cnt_q <= cnt_nx;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = res_value_q;
	assign m_tuser = res_err_q;

endmodule

### tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import itb_pkg::*;

	localparam int TIMER_SLOTS = TIMER_SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [TIME_W-1:0] value;
		logic              err;
	} timer_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	logic                  cfg_wdata;

	// predicted bank state
	logic [TIME_W-1:0] now_count;
	logic [4:0]        slot_count;
	logic [TIME_W-1:0] stamp_mem [TIMER_SLOTS];
	logic              pause_flag;

	timer_result_t pending_results [$];
	bit            idle_en;
	int            stall_left;
	int            cycle_count;
	int            mismatches;
	int            commands_sent;
	int            results_checked;
	int            expiries;
	int            flagged_errors;
	int            pause_writes;

	interval_timer_bank_unit #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// result of one command, updating the predicted bank state
	function automatic timer_result_t bank_step(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] period,
			input logic restamp);
		timer_result_t r;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] span;
		logic allocated;
		r.value = '0;
		r.err = 1'b0;
		allocated = (idx < slot_count);
		elapsed = now_count - stamp_mem[idx];
		span = (period == '0) ? 32'd1 : period;
		case (cmd)
			CMD_TICK: begin
				now_count = now_count + TIME_W'(1);
				r.value = now_count;
			end
			CMD_CREATE: begin
				if (slot_count < TIMER_SLOTS) begin
					stamp_mem[IDX_W'(slot_count)] = now_count;
					r.value = TIME_W'(slot_count);
					slot_count = slot_count + 5'd1;
				end else begin
					r.err = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (!allocated) begin
					r.err = 1'b1;
				end else if (pause_flag) begin
					if (restamp)
						stamp_mem[idx] = now_count;
				end else if (elapsed > span) begin
					stamp_mem[idx] = now_count;
					r.value = elapsed;
				end
			end
			CMD_UPDATE: begin
				if (!allocated)
					r.err = 1'b1;
				else if (!pause_flag)
					stamp_mem[idx] = now_count;
			end
			CMD_READ: begin
				if (!allocated)
					r.err = 1'b1;
				else
					r.value = elapsed;
			end
			default: ;
		endcase
		return r;
	endfunction

	// entered and left at a falling edge; tvalid stays high into the next command
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [TIME_W-1:0] period, input logic restamp);
		timer_result_t r;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, restamp, period, idx};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		r = bank_step(cmd, idx, period, restamp);
		if (cmd == CMD_CHECK && r.value != '0)
			expiries++;
		if (r.err)
			flagged_errors++;
		pending_results.insert(pending_results.size(), r);
		commands_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_paused(input logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		pause_flag = v;
		pause_writes++;
	endtask

	task automatic send_random(input int count);
		int pick;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		logic [TIME_W-1:0] period;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				cmd = CMD_TICK;
			else if (pick < 33)
				cmd = CMD_CREATE;
			else if (pick < 63)
				cmd = CMD_CHECK;
			else if (pick < 73)
				cmd = CMD_UPDATE;
			else if (pick < 94)
				cmd = CMD_READ;
			else
				cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			// mostly live slots, some anywhere in the index range
			if (slot_count != 0 && $urandom_range(0, 9) != 0)
				idx = IDX_W'($urandom_range(0, slot_count - 1));
			else
				idx = IDX_W'($urandom_range(0, 15));
			case ($urandom_range(0, 9))
				7: period = '0;
				8: period = $urandom();
				9: period = '1;
				default: period = $urandom_range(0, 24);
			endcase
			send_cmd(cmd, idx, period, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_unallocated_slots();
		set_paused(1'b0);
		send_cmd(CMD_READ, 4'd0, 32'd5, 1'b0);
		send_cmd(CMD_CHECK, 4'd15, 32'd0, 1'b1);
		send_cmd(CMD_UPDATE, 4'd3, '1, 1'b0);
		send_cmd(CMD_SPARE_LO, 4'd9, '1, 1'b1);
		send_cmd(CMD_SPARE_HI, 4'd15, 32'd0, 1'b0);
	endtask

	task automatic test_create_and_expiry();
		send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_CREATE, 4'd15, 32'd0, 1'b0);
		send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 32'd0, 1'b0);
		// zero period behaves as one, so two elapsed milliseconds expire
		send_cmd(CMD_CHECK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_CHECK, 4'd0, '1, 1'b0);
		send_cmd(CMD_CREATE, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_CHECK, 4'd1, 32'd0, 1'b0);
		send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_UPDATE, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_READ, 4'd2, 32'd0, 1'b0);
	endtask

	task automatic test_pause();
		set_paused(1'b1);
		send_cmd(CMD_TICK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_CHECK, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_READ, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_CHECK, 4'd0, 32'd0, 1'b1);
		send_cmd(CMD_READ, 4'd0, 32'd0, 1'b0);
		send_cmd(CMD_UPDATE, 4'd1, 32'd0, 1'b0);
		send_cmd(CMD_READ, 4'd1, 32'd0, 1'b0);
		set_paused(1'b0);
	endtask

	// bank fills slowly here, so unallocated indexes show up at many fill levels
	task automatic test_random_traffic();
		send_random(700);
	endtask

	task automatic test_random_pause_toggle();
		set_paused(1'b1);
		send_random(250);
		set_paused(1'b0);
		send_random(250);
		set_paused(1'b1);
		send_random(200);
	endtask

	task automatic test_full_rate();
		set_paused(1'b0);
		idle_en = 1'b0;
		send_random(300);
	endtask

	// receiver stalls in bursts of random length; new bursts start only while idle_en is set
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 6) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		timer_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with none expected: result_value %0d error %0b",
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (m_tdata !== want.value) begin
					$error("result_value mismatch: expected %0d, actual %0d",
						want.value, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.err) begin
					$error("error mismatch: expected %0b, actual %0b", want.err, m_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("interval_timer_bank_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		idle_en = 1'b1;
		stall_left = 0;
		now_count = '0;
		slot_count = '0;
		pause_flag = 1'b0;
		foreach (stamp_mem[i])
			stamp_mem[i] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_unallocated_slots();
		test_create_and_expiry();
		test_pause();
		test_random_traffic();
		test_random_pause_toggle();
		test_full_rate();
		drain();
		repeat (8) @(negedge clk);

		$display("%0d commands sent, %0d results checked, %0d pause writes",
			commands_sent, results_checked, pause_writes);
		$display("%0d timer expiries, %0d error flags, %0d of %0d slots allocated",
			expiries, flagged_errors, slot_count, TIMER_SLOTS);
		if (mismatches == 0)
			$display("interval_timer_bank_unit regression: pass");
		else
			$display("interval_timer_bank_unit regression: fail");
		$finish;
	end

endmodule
